/* sv/wcx_pkg.sv */
// ----------------------------------------------------------------------------
// wcx_pkg
// Types, constants and helpers shared by the word chained xor/add cipher.
// ----------------------------------------------------------------------------
package wcx_pkg;

    localparam logic [7:0] BYTE_MASK  = 8'hFF;
    localparam int         SHIFT_TOP  = 24;
    localparam int         SHIFT_HIGH = 16;
    localparam int         LANES      = 4;
    localparam logic [2:0] FULL_COUNT = 3'd4;

    typedef struct packed {
        logic        decode_mode;
        logic        first;
        logic        last;
        logic [7:0]  base_key;
        logic [7:0]  pair_key;
        logic [31:0] data_in;
        logic [2:0]  byte_count;
        logic [7:0]  crc_in;
    } wcx_in_t;

    typedef struct packed {
        logic [31:0] data_out;
        logic [2:0]  out_count;
        logic        out_last;
        logic [7:0]  check_byte;
        logic        check_ok;
    } wcx_out_t;

    typedef struct packed {
        logic advance;
        logic enable;
    } wcx_ctrl_t;

    // Map out-of-range counts onto a full word.
    function automatic logic [2:0] fix_count(input logic [2:0] cnt);
        logic [2:0] res;
        res = cnt;
        if (cnt == 3'd0 || cnt > FULL_COUNT) begin
            res = FULL_COUNT;
        end
        return res;
    endfunction

    function automatic logic [31:0] lane_mask(input logic [2:0] cnt);
        logic [31:0] m;
        m = '0;
        for (int i = 0; i < LANES; i++) begin
            if (3'(i) < cnt) begin
                m[i*8 +: 8] = BYTE_MASK;
            end
        end
        return m;
    endfunction

    function automatic logic [31:0] make_seed(input logic [7:0] e, input logic [7:0] d);
        return (32'(e) << SHIFT_TOP) | (32'(e ^ d) << SHIFT_HIGH) |
               (32'(d) << 8) | 32'(e | d);
    endfunction

endpackage

/* sv/wcx_in_stage.sv */
// ----------------------------------------------------------------------------
// wcx_in_stage
// Input register: holds one request until the core consumes it.
// ----------------------------------------------------------------------------
module wcx_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  wcx_pkg::wcx_in_t s_item,
    input  logic            advance,
    output logic            in_valid,
    output wcx_pkg::wcx_in_t in_item
);
    import wcx_pkg::*;

    logic    vld_reg;
    logic    vld_next;
    wcx_in_t item_reg;

    // Take a new request when empty or when the held one moves on this cycle.
    assign s_ready  = !vld_reg || advance;
    assign vld_next = (s_valid && s_ready) ? 1'b1 : (advance ? 1'b0 : vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign in_valid = vld_reg;
    assign in_item  = item_reg;

endmodule

/* sv/wcx_core.sv */
// ----------------------------------------------------------------------------
// wcx_core
// Key state and single-pass cipher datapath for one word.
// ----------------------------------------------------------------------------
module wcx_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  wcx_pkg::wcx_ctrl_t ctrl,
    input  wcx_pkg::wcx_in_t   item,
    output wcx_pkg::wcx_out_t  result
);
    import wcx_pkg::*;

    logic [31:0] chain_reg, chain_next;
    logic [31:0] sum_reg, sum_next;
    logic [7:0]  check_reg, check_next;
    logic [7:0]  tail_reg, tail_next;

    logic [31:0] seed, ck0, sk0, w, res, diff, plain;
    logic [7:0]  rc0, tk0, b, o;
    logic [2:0]  cnt;

    always_comb begin
        w     = item.data_in;
        cnt   = fix_count(item.byte_count);
        seed  = make_seed(item.base_key, item.pair_key);
        ck0   = item.first ? seed : chain_reg;
        sk0   = item.first ? ~seed : sum_reg;
        rc0   = item.first ? 8'd0 : check_reg;
        tk0   = item.first ? item.pair_key : tail_reg;
        diff  = w - sk0;
        plain = diff ^ ck0;
        b     = '0;
        o     = '0;
        res   = '0;

        chain_next = chain_reg;
        sum_next   = sum_reg;
        check_next = check_reg;
        tail_next  = tail_reg;

        result           = '0;
        result.out_count = cnt;
        result.out_last  = item.last;

        if (!ctrl.enable) begin
            result.data_out = w & lane_mask(cnt);
        end else begin
            chain_next = ck0;
            sum_next   = sk0;
            check_next = rc0;
            tail_next  = tk0;
            if (cnt == FULL_COUNT) begin
                if (!item.decode_mode) begin
                    chain_next = ck0 ^ w;
                    sum_next   = sk0 + w;
                    res        = (ck0 ^ w) + sk0;
                    check_next = rc0 ^ res[7:0];
                end else begin
                    check_next = rc0 ^ w[7:0];
                    chain_next = ck0 ^ plain;
                    sum_next   = sk0 + plain;
                    res        = plain;
                end
            end else begin
                // Tail bytes: xor each valid lane with the tail key.
                for (int i = 0; i < LANES; i++) begin
                    if (3'(i) < cnt) begin
                        b = w[i*8 +: 8];
                        o = b ^ tk0;
                        check_next = check_next ^ (item.decode_mode ? b : o);
                        res[i*8 +: 8] = o;
                    end
                end
            end
            result.data_out = res;
            if (item.last) begin
                if (!item.decode_mode) begin
                    result.check_byte = check_next ^ tk0;
                end else begin
                    result.check_ok = ((item.crc_in ^ tk0) == check_next);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= '0;
            sum_reg   <= '0;
            check_reg <= '0;
            tail_reg  <= '0;
        end else if (ctrl.advance) begin
            chain_reg <= chain_next;
            sum_reg   <= sum_next;
            check_reg <= check_next;
            tail_reg  <= tail_next;
        end
    end

endmodule

/* sv/word_chained_xor_add_cipher.sv */
// ----------------------------------------------------------------------------
// word_chained_xor_add_cipher
// Packet cipher over 32-bit little-endian words with chained xor/add keys.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_valid/s_ready/s_item, one word per request; results
//   leave on m_valid/m_ready/m_item, one per request, in order.
//   cfg_wr_en/cfg_wr_data write the enable bit; write it only while idle.
//   From input acceptance to m_valid a request passes one input register,
//   then the cipher logic and key update feeding the result register.
//   Throughput is one word per cycle while m_ready stays high; the key chain
//   closes combinationally between the input register and the result register.
//   Mark the first word of a packet with first to load its keys; last closes
//   the packet and carries the check byte (encode) or check_ok (decode).
//   When the receiver stalls, the result register holds, the input register
//   fills, and s_ready drops until m_ready returns.
//   Synchronous reset clears both stages, the key state and enable (pass
//   through); no request is lost once accepted after reset.
// ----------------------------------------------------------------------------
module word_chained_xor_add_cipher (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  wcx_pkg::wcx_in_t  s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output wcx_pkg::wcx_out_t m_item
);
    import wcx_pkg::*;

    logic      enable_reg;
    logic      in_valid;
    wcx_in_t   in_item;
    wcx_ctrl_t ctrl;
    wcx_out_t  result;
    logic      out_vld_reg, out_vld_next;
    wcx_out_t  out_item_reg;

    assign ctrl.advance = in_valid && (!out_vld_reg || m_ready);
    assign ctrl.enable  = enable_reg;
    assign out_vld_next = ctrl.advance ? 1'b1 : (m_ready ? 1'b0 : out_vld_reg);

    wcx_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .advance  (ctrl.advance),
        .in_valid (in_valid),
        .in_item  (in_item)
    );

    wcx_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .item    (in_item),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                enable_reg <= cfg_wr_data;
            end
            out_vld_reg <= out_vld_next;
        end
        if (ctrl.advance) begin
            out_item_reg <= result;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_item  = out_item_reg;

endmodule

/* sv/wcx_checker.sv */
// ----------------------------------------------------------------------------
// wcx_checker
// Port-level checks for the cipher, bound to the top level.
// ----------------------------------------------------------------------------
module wcx_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input wcx_pkg::wcx_out_t m_item
);
    import wcx_pkg::*;

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_item))
        else $error("result changed while stalled");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.out_count != 3'd0 && m_item.out_count <= FULL_COUNT))
        else $error("out_count outside 1 to 4");

    // Check outputs only on the last result of a packet.
    a_check_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.out_last |-> (m_item.check_byte == 8'd0 && !m_item.check_ok))
        else $error("check output set on a non-final result");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind word_chained_xor_add_cipher wcx_checker u_wcx_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
